FILE: hw/rtl/swlfu_pkg.sv
// shared types and constants for the size-weighted lfu cache table
`default_nettype none
package swlfu_pkg;

  localparam int unsigned KEY_W   = 50;
  localparam int unsigned SIZE_W  = 26;
  localparam int unsigned USED_W  = 27;
  localparam int unsigned HITS_W  = 32;
  localparam int unsigned STAMP_W = 40;
  localparam int unsigned APB_W   = 32;
  localparam int unsigned ADDR_W  = 2;

  localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(52428800);
  localparam logic [HITS_W-1:0] HITS_MAX  = '1;

  typedef enum logic [0:0] {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    K_EVICT = 3'd0,
    K_STORE = 3'd1,
    K_DUP   = 3'd2,
    K_BIG   = 3'd3,
    K_HIT   = 3'd4,
    K_MISS  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SIZE_W-1:0]  size;
    logic [HITS_W-1:0]  hits;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic  accept;
    logic  scan_start;
    logic  do_hit;
    logic  do_evict;
    logic  do_store;
    logic  emit;
    kind_t kind;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic is_get;
    logic scan_done;
    logic match;
    logic free;
    logic victim;
    logic too_big;
    logic overflow;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/swlfu_ctrl.sv
// controller state machine sequencing scans, evictions and results
`default_nettype none
module swlfu_ctrl
  import swlfu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = K_MISS;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept     = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
          if (sts.is_get) begin
            if (sts.match) begin
              cmd.kind   = K_HIT;
              cmd.do_hit = 1'b1;
            end else begin
              cmd.kind = K_MISS;
            end
          end else if (sts.match) begin
            cmd.kind = K_DUP;
          end else if (sts.too_big) begin
            cmd.kind = K_BIG;
          end else if ((sts.overflow || !sts.free) && sts.victim) begin
            cmd.kind       = K_EVICT;
            cmd.last       = 1'b0;
            cmd.do_evict   = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            cmd.kind     = K_STORE;
            cmd.do_store = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/swlfu_dp.sv
// datapath: entry memory, table scan, counters and result register
`default_nettype none
module swlfu_dp
  import swlfu_pkg::*;
#(
  parameter int unsigned ENTRIES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic              in_opcode,
  input  wire logic [KEY_W-1:0]  in_file_key,
  input  wire logic [SIZE_W-1:0] in_file_size,
  input  wire logic              cap_we,
  input  wire logic [SIZE_W-1:0] cap_wdata,
  output logic [SIZE_W-1:0]      cap_q,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_kind,
  output logic [KEY_W-1:0]       out_result_key,
  output logic [SIZE_W-1:0]      out_used_bytes,
  output logic                   out_last
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  entry_t mem [ENTRIES];
  entry_t rd_q_r;

  logic [ENTRIES-1:0] valid_r;
  logic [SIZE_W-1:0]  cap_r;
  logic [USED_W-1:0]  used_r;
  logic [STAMP_W-1:0] clock_r;
  logic               op_r;
  logic [KEY_W-1:0]   key_r;
  logic [SIZE_W-1:0]  size_r;

  logic          scan_run_r;
  logic [IW-1:0] scan_idx_r;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;

  logic               match_r;
  logic [IW-1:0]      match_idx_r;
  logic [SIZE_W-1:0]  match_size_r;
  logic [HITS_W-1:0]  match_hits_r;
  logic               free_r;
  logic [IW-1:0]      free_idx_r;
  logic               vic_r;
  logic [IW-1:0]      vic_idx_r;
  logic [KEY_W-1:0]   vic_key_r;
  logic [SIZE_W-1:0]  vic_size_r;
  logic [HITS_W-1:0]  vic_hits_r;
  logic [STAMP_W-1:0] vic_stamp_r;

  logic               out_valid_r;
  logic [2:0]         out_kind_r;
  logic [KEY_W-1:0]   out_key_r;
  logic [SIZE_W-1:0]  out_used_r;
  logic               out_last_r;

  logic               cmp_v;
  logic               vic_better;
  logic               out_free;
  logic [USED_W:0]    need;
  logic [USED_W-1:0]  used_nxt;
  logic [STAMP_W-1:0] stamp_nxt;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  entry_t             wr_word;

  assign cmp_v      = valid_r[cmp_idx_r];
  assign vic_better = !vic_r || (rd_q_r.hits < vic_hits_r) ||
                      ((rd_q_r.hits == vic_hits_r) && (rd_q_r.stamp < vic_stamp_r));
  assign out_free   = !out_valid_r || out_ready;
  assign need       = {1'b0, used_r} + (USED_W+1)'(size_r);
  assign stamp_nxt  = clock_r + STAMP_W'(1);

  always_comb begin
    used_nxt = used_r;
    if (cmd.do_evict) begin
      used_nxt = (used_r >= USED_W'(vic_size_r)) ? used_r - USED_W'(vic_size_r) : '0;
    end else if (cmd.do_store) begin
      used_nxt = used_r + USED_W'(size_r);
    end
  end

  always_comb begin
    wr_en         = cmd.do_hit || cmd.do_store;
    wr_addr       = cmd.do_hit ? match_idx_r : (free_r ? free_idx_r : '0);
    wr_word.key   = key_r;
    wr_word.size  = cmd.do_hit ? match_size_r : size_r;
    wr_word.hits  = cmd.do_hit ? ((match_hits_r == HITS_MAX) ? match_hits_r
                                  : match_hits_r + HITS_W'(1)) : '0;
    wr_word.stamp = stamp_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (scan_run_r) begin
      rd_q_r <= mem[scan_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cap_r       <= CAP_RESET;
      used_r      <= '0;
      clock_r     <= '0;
      scan_run_r  <= 1'b0;
      scan_idx_r  <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cap_we) begin
        cap_r <= cap_wdata;
      end
      if (cmd.scan_start) begin
        scan_run_r <= 1'b1;
        scan_idx_r <= '0;
      end else if (scan_run_r) begin
        if (scan_idx_r == LAST_IDX) begin
          scan_run_r <= 1'b0;
        end else begin
          scan_idx_r <= scan_idx_r + IW'(1);
        end
      end
      cmp_vld_r <= scan_run_r;
      if (cmd.do_evict) begin
        valid_r[vic_idx_r] <= 1'b0;
      end
      if (cmd.do_store) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.do_hit || cmd.do_store) begin
        clock_r <= stamp_nxt;
      end
      used_r <= used_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_idx_r;
    if (cmd.accept) begin
      op_r   <= in_opcode;
      key_r  <= in_file_key;
      size_r <= in_file_size;
    end
    if (cmd.scan_start) begin
      match_r <= 1'b0;
      free_r  <= 1'b0;
      vic_r   <= 1'b0;
    end else if (cmp_vld_r) begin
      if (cmp_v && !match_r && (rd_q_r.key == key_r)) begin
        match_r      <= 1'b1;
        match_idx_r  <= cmp_idx_r;
        match_size_r <= rd_q_r.size;
        match_hits_r <= rd_q_r.hits;
      end
      if (!cmp_v && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= cmp_idx_r;
      end
      if (cmp_v && vic_better) begin
        vic_r       <= 1'b1;
        vic_idx_r   <= cmp_idx_r;
        vic_key_r   <= rd_q_r.key;
        vic_size_r  <= rd_q_r.size;
        vic_hits_r  <= rd_q_r.hits;
        vic_stamp_r <= rd_q_r.stamp;
      end
    end
    if (cmd.emit) begin
      out_kind_r <= cmd.kind;
      out_key_r  <= cmd.do_evict ? vic_key_r : key_r;
      out_used_r <= used_nxt[SIZE_W-1:0];
      out_last_r <= cmd.last;
    end
  end

  always_comb begin
    sts.is_get    = (op_r == OP_GET);
    sts.scan_done = cmp_vld_r && (cmp_idx_r == LAST_IDX);
    sts.match     = match_r;
    sts.free      = free_r;
    sts.victim    = vic_r;
    sts.too_big   = size_r > cap_r;
    sts.overflow  = need > (USED_W+1)'(cap_r);
    sts.out_free  = out_free;
  end

  assign cap_q          = cap_r;
  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_result_key = out_key_r;
  assign out_used_bytes = out_used_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

FILE: hw/rtl/size_weighted_lfu_cache_table_top.sv
// top level of the size-weighted lfu cache table with register port
// each item costs one table scan plus a decide step, the scan length
// set by the single read port of the entry memory walked one slot a cycle
// a put with k evictions does k+1 scans, giving k+1 results
// one item at a time: a new item is taken only in the idle state
// reset clears valid bits, byte count and clock, capacity to 52428800
`default_nettype none
module size_weighted_lfu_cache_table_top
  import swlfu_pkg::*;
#(
  parameter int unsigned ENTRIES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_opcode,
  input  wire logic [KEY_W-1:0]  in_file_key,
  input  wire logic [SIZE_W-1:0] in_file_size,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_kind,
  output logic [KEY_W-1:0]       out_result_key,
  output logic [SIZE_W-1:0]      out_used_bytes,
  output logic                   out_last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]       prdata,
  output logic                   pready
);

  cmd_t              cmd;
  sts_t              sts;
  logic              cap_we;
  logic [SIZE_W-1:0] cap_q;

  assign pready = 1'b1;
  assign cap_we = psel && penable && pwrite && (paddr == '0);
  assign prdata = (paddr == '0) ? APB_W'(cap_q) : '0;

  swlfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swlfu_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_file_key    (in_file_key),
    .in_file_size   (in_file_size),
    .cap_we         (cap_we),
    .cap_wdata      (pwdata[SIZE_W-1:0]),
    .cap_q          (cap_q),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_result_key (out_result_key),
    .out_used_bytes (out_used_bytes),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

FILE: verif/swlfu_checker.sv
// cache table checker: predicts results from accepted items and compares them
`default_nettype none
module swlfu_checker
  import swlfu_pkg::*;
#(
  parameter int unsigned ENTRIES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic              in_opcode,
  input  wire logic [KEY_W-1:0]  in_file_key,
  input  wire logic [SIZE_W-1:0] in_file_size,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [2:0]        out_kind,
  input  wire logic [KEY_W-1:0]  out_result_key,
  input  wire logic [SIZE_W-1:0] out_used_bytes,
  input  wire logic              out_last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [APB_W-1:0]  pwdata,
  input  wire logic              pready,
  output int                     pending,
  output int                     errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t             kind;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] used;
    logic              last;
  } cache_result_t;

  cache_result_t     due_results[$];
  logic              slot_valid [ENTRIES];
  logic [KEY_W-1:0]  slot_key   [ENTRIES];
  logic [SIZE_W-1:0] slot_size  [ENTRIES];
  logic [HITS_W-1:0] slot_hits  [ENTRIES];
  logic [STAMP_W-1:0] slot_stamp[ENTRIES];
  logic [USED_W-1:0] bytes_used;
  logic [STAMP_W-1:0] use_clock;
  logic [SIZE_W-1:0] capacity;

  function automatic int lookup_key(logic [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++) if (slot_valid[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < ENTRIES; i++) if (!slot_valid[i]) return i;
    return -1;
  endfunction

  function automatic int lfu_victim();
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!slot_valid[i]) continue;
      if (best < 0 || slot_hits[i] < slot_hits[best] ||
          (slot_hits[i] == slot_hits[best] && slot_stamp[i] < slot_stamp[best]))
        best = i;
    end
    return best;
  endfunction

  task automatic push_result(kind_t k, logic [KEY_W-1:0] key, logic last);
    cache_result_t r;
    r.kind = k;
    r.key  = key;
    r.used = bytes_used[SIZE_W-1:0];
    r.last = last;
    due_results.insert(due_results.size(), r);
  endtask

  task automatic predict_cache_op(logic op, logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size);
    int s;
    int v;
    s = lookup_key(key);
    if (op == OP_GET) begin
      if (s < 0) begin
        push_result(K_MISS, key, 1'b1);
      end else begin
        if (slot_hits[s] != HITS_MAX) slot_hits[s] = slot_hits[s] + HITS_W'(1);
        use_clock = use_clock + STAMP_W'(1);
        slot_stamp[s] = use_clock;
        push_result(K_HIT, key, 1'b1);
      end
    end else if (s >= 0) begin
      push_result(K_DUP, key, 1'b1);
    end else if (size > capacity) begin
      push_result(K_BIG, key, 1'b1);
    end else begin
      while ({1'b0, bytes_used} + size > capacity || free_slot() < 0) begin
        v = lfu_victim();
        if (v < 0) break;
        slot_valid[v] = 1'b0;
        bytes_used = (bytes_used >= slot_size[v]) ? bytes_used - slot_size[v] : '0;
        push_result(K_EVICT, slot_key[v], 1'b0);
      end
      s = free_slot();
      if (s < 0) s = 0;
      slot_valid[s] = 1'b1;
      slot_key[s]   = key;
      slot_size[s]  = size;
      slot_hits[s]  = '0;
      use_clock     = use_clock + STAMP_W'(1);
      slot_stamp[s] = use_clock;
      bytes_used    = bytes_used + USED_W'(size);
      push_result(K_STORE, key, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    cache_result_t e;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
      bytes_used = '0;
      use_clock  = '0;
      capacity   = CAP_RESET;
      errors     = 0;
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == '0)
        capacity = pwdata[SIZE_W-1:0];
      if (in_valid && in_ready)
        predict_cache_op(in_opcode, in_file_key, in_file_size);
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%t unexpected result: kind %0d key %h used %0d last %0b", $realtime,
                   out_kind, out_result_key, out_used_bytes, out_last);
        end else begin
          e = due_results.pop_front();
          if (out_kind != e.kind || out_result_key != e.key ||
              out_used_bytes != e.used || out_last != e.last) begin
            errors++;
            $display("%t mismatch: expected kind %0d key %h used %0d last %0b", $realtime,
                     e.kind, e.key, e.used, e.last);
            $display("%t           actual   kind %0d key %h used %0d last %0b", $realtime,
                     out_kind, out_result_key, out_used_bytes, out_last);
          end
        end
      end
    end
    pending = due_results.size();
  end
endmodule
`default_nettype wire

FILE: verif/tb.sv
// testbench top: stimulus, register writes and verdict for the cache table
`default_nettype none
module tb;
  import swlfu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_opcode = OP_PUT;
  logic [KEY_W-1:0]  in_file_key = '0;
  logic [SIZE_W-1:0] in_file_size = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        out_kind;
  logic [KEY_W-1:0]  out_result_key;
  logic [SIZE_W-1:0] out_used_bytes;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [APB_W-1:0]  pwdata = '0;
  logic [APB_W-1:0]  prdata;
  logic              pready;
  int                pending;
  int                errors;
  int                items_taken = 0;
  bit                calm = 1'b0;
  logic [SIZE_W-1:0] cap_now = CAP_RESET;
  logic [KEY_W-1:0]  key_pool [48];

  always #10 clk = ~clk;

  size_weighted_lfu_cache_table_top i_dut (.*);

  swlfu_checker i_checker (.*);

  always @(posedge clk) if (in_valid && in_ready) items_taken <= items_taken + 1;

  // sink side stalls in bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 17);
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // called at a falling edge
  task automatic send_item(logic op, logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size);
    int start;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_opcode    <= op;
    in_file_key  <= key;
    in_file_size <= size;
    in_valid     <= 1'b1;
    start = items_taken;
    wait (items_taken != start);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (1300) @(negedge clk);
  endtask

  task automatic write_capacity(logic [SIZE_W-1:0] cap);
    settle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= APB_W'(cap);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_now = cap;
    @(negedge clk);
  endtask

  task automatic random_item();
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    int r;
    r = $urandom_range(0, 19);
    key = (r == 0) ? KEY_W'({$urandom, $urandom}) : key_pool[$urandom_range(0, 47)];
    r = $urandom_range(0, 19);
    if (r < 2) size = '0;
    else if (r < 4) size = SIZE_W'($urandom);
    else size = SIZE_W'($urandom_range(0, cap_now / 6));
    send_item($urandom_range(0, 9) < 6 ? OP_PUT : OP_GET, key, size);
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 48; i++) key_pool[i] = KEY_W'({$urandom, $urandom});
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(OP_PUT, key_pool[0], '0);
    send_item(OP_PUT, key_pool[1], SIZE_MAX);
    send_item(OP_PUT, key_pool[1], CAP_RESET);
    send_item(OP_PUT, key_pool[0], 26'd5);
    send_item(OP_GET, key_pool[0], SIZE_MAX);
    send_item(OP_GET, key_pool[2], '0);
    send_item(OP_PUT, key_pool[2], 26'd100);
    send_item(OP_GET, key_pool[2], '0);
    send_item(OP_PUT, key_pool[3], 26'd10);
    write_capacity('0);
    send_item(OP_PUT, key_pool[4], 26'd1);
    send_item(OP_PUT, key_pool[4], '0);
    write_capacity(SIZE_MAX);
    for (int i = 5; i < 40; i++) send_item(OP_PUT, key_pool[i], 26'd3);
    send_item(OP_GET, key_pool[20], '0);
    send_item(OP_PUT, key_pool[40], SIZE_MAX);

    write_capacity(26'd1000);
    for (int i = 0; i < 35; i++) begin
      random_item();
      if (i == 25) begin
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
    end
    write_capacity(26'd1);
    for (int i = 0; i < 15; i++) random_item();
    write_capacity(SIZE_MAX);
    for (int i = 0; i < 35; i++) random_item();
    write_capacity(26'd40);
    calm = 1'b1;
    for (int i = 0; i < 22; i++) random_item();
    write_capacity(CAP_RESET);
    for (int i = 0; i < 15; i++) random_item();

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (1300) @(negedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
